// ----- rtl/core/axhp_pkg.sv -----
package axhp_pkg;

    // Frame layout constants
    localparam int CALL_LEN      = 6;
    localparam int MAX_DIGIS     = 8;
    localparam int MAX_INFO      = 256;
    localparam int MIN_FRAME_LEN = 15;
    localparam int FCS_LEN       = 2;

    // Counter widths
    localparam int CNT_W   = 10;
    localparam int POS_W   = 3;
    localparam int DIGI_W  = 4;
    localparam int INFO_W  = 9;

    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};
    localparam logic [DIGI_W-1:0] DIGI_SAT = {DIGI_W{1'b1}};

    // Byte roles double as parser phases
    typedef enum logic [3:0] {
        PH_DCALL = 4'd0,
        PH_DSSID = 4'd1,
        PH_SCALL = 4'd2,
        PH_SSSID = 4'd3,
        PH_GCALL = 4'd4,
        PH_GSSID = 4'd5,
        PH_CTRL  = 4'd6,
        PH_PID   = 4'd7,
        PH_DATA  = 4'd8,
        PH_IGN   = 4'd9
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_DIGI_OVF  = 2'd2,
        ST_BAD_LEN   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CR_UNKNOWN = 2'd0,
        CR_RESP    = 2'd1,
        CR_CMD     = 2'd2
    } cmd_resp_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } axhp_in_t;

    typedef struct packed {
        logic [3:0]        byte_role;
        logic [2:0]        digi_index;
        logic [3:0]        ssid_value;
        logic              repeated_flag;
        logic              frame_done;
        logic [1:0]        frame_status;
        logic [1:0]        cmd_resp;
        logic [DIGI_W-1:0] digi_count;
        logic [7:0]        control_byte;
        logic [7:0]        pid_byte;
        logic              has_pid;
        logic [INFO_W-1:0] info_length;
    } axhp_out_t;

    // Handshake between the pipeline stages
    typedef struct packed {
        logic valid;
        logic take;
    } axhp_hs_t;

    // I frames and UI frames carry a PID byte
    function automatic logic takes_pid(input logic [7:0] c);
        logic r;
        r = (c[0] == 1'b0) || ((c & 8'hEF) == 8'h03);
        return r;
    endfunction

endpackage

// ----- rtl/core/ax25_header_parser_unit.sv -----
// AX.25 address and control field parser.
// Input channel (s_valid/s_ready/s_data): one frame byte per word, with
// last_byte set on the final byte of each frame.
// Result channel (m_valid/m_ready/m_data): exactly one result word per input
// word, giving the byte's role, digipeater index, SSID and C/H bit. On the
// last byte the word also carries the frame summary: status, command/response,
// digipeater count, control, PID and payload length; otherwise those are zero.
// From input accept to m_valid a word passes the input register, then the
// result register fed by the combinational classifier.
// Throughput: one byte per cycle while m_ready stays high; the header walk
// state updates once per byte taken and never blocks the next byte.
// Reset (aresetn low, synchronous): both pipeline registers empty, the parser
// waits for the first destination callsign byte.
// Stall: when m_ready is low the result register holds; the input register
// takes one more word, then s_ready drops until the receiver drains.
module ax25_header_parser_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  axhp_pkg::axhp_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output axhp_pkg::axhp_out_t m_data
);
    import axhp_pkg::*;

    logic      in_valid;
    axhp_in_t  in_data;
    logic      take;
    axhp_hs_t  hs;
    axhp_out_t result;

    axhp_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .take     (take),
        .in_valid (in_valid),
        .in_data  (in_data)
    );

    assign hs.valid = in_valid;
    assign hs.take  = take;

    axhp_classifier u_cls (
        .aclk    (aclk),
        .aresetn (aresetn),
        .hs      (hs),
        .in_data (in_data),
        .result  (result)
    );

    axhp_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (in_valid),
        .take     (take),
        .result   (result),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

`ifndef NO_ASSERTIONS
    // An empty result register must never block the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with empty result register");

    // Summary fields stay zero except on the last byte
    a_summary_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.frame_done) |->
            (m_data.frame_status == ST_OK && m_data.info_length == '0 &&
             m_data.has_pid == 1'b0 && m_data.digi_count == '0))
        else $error("summary fields set on a non-final byte");

    // A good frame never reports a payload beyond the limit
    a_info_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.frame_done && m_data.frame_status == ST_OK) |->
            ({1'b0, m_data.info_length} <= (INFO_W+1)'(MAX_INFO)))
        else $error("payload length above limit on a good frame");

    // Digipeater index only on digipeater bytes
    a_digi_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.digi_index != 3'd0) |->
            (m_data.byte_role == PH_GCALL || m_data.byte_role == PH_GSSID))
        else $error("digi_index set on a non-digipeater byte");
`endif

endmodule

// ----- rtl/core/axhp_in_stage.sv -----
module axhp_in_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  axhp_pkg::axhp_in_t  s_data,
    input  logic                take,
    output logic                in_valid,
    output axhp_pkg::axhp_in_t  in_data
);
    import axhp_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    axhp_in_t data_reg;

    // Accept a word whenever the register is empty or drains this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the payload until the next accept
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign in_valid = valid_reg;
    assign in_data  = data_reg;

endmodule

// ----- rtl/core/axhp_classifier.sv -----
module axhp_classifier (
    input  logic                aclk,
    input  logic                aresetn,
    input  axhp_pkg::axhp_hs_t  hs,
    input  axhp_pkg::axhp_in_t  in_data,
    output axhp_pkg::axhp_out_t result
);
    import axhp_pkg::*;

    phase_t            phase_reg, phase_next;
    logic [CNT_W-1:0]  byte_count_reg, byte_count_next;
    logic [POS_W-1:0]  call_pos_reg, call_pos_next;
    logic [DIGI_W-1:0] digis_reg, digis_next;
    logic              dest_cbit_reg, dest_cbit_next;
    logic              src_cbit_reg, src_cbit_next;
    logic [7:0]        control_reg, control_next;
    logic [7:0]        pid_reg, pid_next;
    logic              pid_present_reg, pid_present_next;
    logic [CNT_W-1:0]  header_bytes_reg, header_bytes_next;
    logic              digi_ovf_reg, digi_ovf_next;

    logic [7:0]        b;
    logic [CNT_W-1:0]  cnt;
    logic [DIGI_W-1:0] digis_inc;
    logic [CNT_W:0]    hdr_plus_fcs;
    logic [CNT_W-1:0]  info_full;
    logic [1:0]        cr_idx;
    phase_t            role;
    logic [2:0]        didx;
    logic [3:0]        ssid;
    logic              rep;
    status_t           status;

    assign b   = in_data.data_byte;
    assign cnt = (byte_count_reg != CNT_MAX) ? byte_count_reg + 1'b1 : CNT_MAX;
    assign digis_inc = (digis_reg != DIGI_SAT) ? digis_reg + 1'b1 : digis_reg;

    // Advance the header walk by one byte
    always_comb begin
        phase_next        = phase_reg;
        call_pos_next     = call_pos_reg;
        digis_next        = digis_reg;
        dest_cbit_next    = dest_cbit_reg;
        src_cbit_next     = src_cbit_reg;
        control_next      = control_reg;
        pid_next          = pid_reg;
        pid_present_next  = pid_present_reg;
        header_bytes_next = header_bytes_reg;
        digi_ovf_next     = digi_ovf_reg;
        role              = phase_reg;
        didx              = 3'd0;
        ssid              = 4'd0;
        rep               = 1'b0;
        unique case (phase_reg)
            PH_DCALL, PH_SCALL, PH_GCALL: begin
                if (phase_reg == PH_GCALL) begin
                    didx = digis_reg[2:0];
                end
                if (call_pos_reg == POS_W'(CALL_LEN - 1)) begin
                    call_pos_next = '0;
                    phase_next    = phase_t'(phase_reg + 4'd1);
                end else begin
                    call_pos_next = call_pos_reg + 1'b1;
                end
            end
            PH_DSSID: begin
                ssid           = b[4:1];
                rep            = b[7];
                dest_cbit_next = b[7];
                phase_next     = PH_SCALL;
            end
            PH_SSSID: begin
                ssid          = b[4:1];
                rep           = b[7];
                src_cbit_next = b[7];
                if (b[0]) begin
                    phase_next = PH_CTRL;
                end else if (digis_reg < DIGI_W'(MAX_DIGIS)) begin
                    phase_next = PH_GCALL;
                end else begin
                    digi_ovf_next = 1'b1;
                    phase_next    = PH_IGN;
                end
            end
            PH_GSSID: begin
                ssid       = b[4:1];
                rep        = b[7];
                didx       = digis_reg[2:0];
                digis_next = digis_inc;
                if (b[0]) begin
                    phase_next = PH_CTRL;
                end else if (digis_inc >= DIGI_W'(MAX_DIGIS)) begin
                    digi_ovf_next = 1'b1;
                    phase_next    = PH_IGN;
                end else begin
                    phase_next = PH_GCALL;
                end
            end
            PH_CTRL: begin
                control_next      = b;
                header_bytes_next = cnt;
                phase_next        = takes_pid(b) ? PH_PID : PH_DATA;
            end
            PH_PID: begin
                pid_next          = b;
                pid_present_next  = 1'b1;
                header_bytes_next = cnt;
                phase_next        = PH_DATA;
            end
            PH_DATA: begin
            end
            default: begin
                role       = PH_IGN;
                phase_next = PH_IGN;
            end
        endcase
    end

    // Frame summary from the state after this byte
    assign hdr_plus_fcs = {1'b0, header_bytes_next} + (CNT_W+1)'(FCS_LEN);
    assign info_full    = cnt - header_bytes_next - CNT_W'(FCS_LEN);
    assign cr_idx       = {dest_cbit_next, src_cbit_next};

    always_comb begin
        priority if (cnt < CNT_W'(MIN_FRAME_LEN)) begin
            status = ST_SHORT;
        end else if (digi_ovf_next) begin
            status = ST_DIGI_OVF;
        end else if (phase_next != PH_DATA || {1'b0, cnt} < hdr_plus_fcs) begin
            status = ST_BAD_LEN;
        end else if (info_full > CNT_W'(MAX_INFO)) begin
            status = ST_BAD_LEN;
        end else begin
            status = ST_OK;
        end
    end

    always_comb begin
        result               = '0;
        result.byte_role     = role;
        result.digi_index    = didx;
        result.ssid_value    = ssid;
        result.repeated_flag = rep;
        if (in_data.last_byte) begin
            result.frame_done   = 1'b1;
            result.frame_status = status;
            unique case (cr_idx)
                2'b01:   result.cmd_resp = CR_RESP;
                2'b10:   result.cmd_resp = CR_CMD;
                default: result.cmd_resp = CR_UNKNOWN;
            endcase
            result.digi_count   = digis_next;
            result.control_byte = control_next;
            result.pid_byte     = pid_present_next ? pid_next : 8'd0;
            result.has_pid      = pid_present_next;
            result.info_length  = (status == ST_OK) ? info_full[INFO_W-1:0] : '0;
        end
    end

    // Commit state on each word taken; restart after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_DCALL;
            byte_count_reg   <= '0;
            call_pos_reg     <= '0;
            digis_reg        <= '0;
            dest_cbit_reg    <= 1'b0;
            src_cbit_reg     <= 1'b0;
            control_reg      <= '0;
            pid_reg          <= '0;
            pid_present_reg  <= 1'b0;
            header_bytes_reg <= '0;
            digi_ovf_reg     <= 1'b0;
        end else if (hs.valid && hs.take) begin
            if (in_data.last_byte) begin
                phase_reg        <= PH_DCALL;
                byte_count_reg   <= '0;
                call_pos_reg     <= '0;
                digis_reg        <= '0;
                dest_cbit_reg    <= 1'b0;
                src_cbit_reg     <= 1'b0;
                control_reg      <= '0;
                pid_reg          <= '0;
                pid_present_reg  <= 1'b0;
                header_bytes_reg <= '0;
                digi_ovf_reg     <= 1'b0;
            end else begin
                phase_reg        <= phase_next;
                byte_count_reg   <= cnt;
                call_pos_reg     <= call_pos_next;
                digis_reg        <= digis_next;
                dest_cbit_reg    <= dest_cbit_next;
                src_cbit_reg     <= src_cbit_next;
                control_reg      <= control_next;
                pid_reg          <= pid_next;
                pid_present_reg  <= pid_present_next;
                header_bytes_reg <= header_bytes_next;
                digi_ovf_reg     <= digi_ovf_next;
            end
        end
    end

endmodule

// ----- rtl/core/axhp_out_stage.sv -----
module axhp_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                take,
    input  axhp_pkg::axhp_out_t result,
    output logic                m_valid,
    input  logic                m_ready,
    output axhp_pkg::axhp_out_t m_data
);
    import axhp_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    logic      room;
    axhp_out_t data_reg;

    // Load a new result when the register is empty or being drained
    assign room = !valid_reg || m_ready;
    assign take = in_valid && room;

    always_comb begin
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result while the receiver stalls
    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule
